// ----- hw/rtl/rsfd_pkg.sv -----
// Package for the RC servo frame decoder: state codes, frame constants
// and the control structs passed between its submodules. No dependencies.
`timescale 1ns / 1ps

package rsfd_pkg;

  localparam logic [7:0] HDR_BYTE      = 8'h0F;
  localparam logic [7:0] END_BYTE      = 8'h00;
  localparam int unsigned RAW_W        = 11;
  localparam int unsigned WIDTH_W      = 12;
  localparam int unsigned CH_IDX_W     = 4;
  localparam int unsigned BITCNT_W     = $clog2(RAW_W);
  localparam int unsigned FLAGS_W      = 4;
  localparam logic [WIDTH_W-1:0] WIDTH_LO = 12'd880;
  localparam logic [7:0] TIMEOUT_RESET = 8'd10;

  typedef enum logic [2:0] {
    ST_HUNT = 3'b001,
    ST_DATA = 3'b010,
    ST_END  = 3'b100
  } parse_state_e;

  // parser -> frame register and channel unit
  typedef struct packed {
    logic       store;
    logic [7:0] data;
    logic       start;
  } frame_ctrl_t;

  // frame register -> channel unit
  typedef struct packed {
    logic               data_bit;
    logic [FLAGS_W-1:0] flags;
  } bit_stream_t;

endpackage

// ----- hw/rtl/rsfd_parser.sv -----
// Frame parser: header hunt, data byte count and millisecond timeout.
// Depends on rsfd_pkg.
`timescale 1ns / 1ps

module rsfd_parser #(
  parameter int unsigned DATA_BYTES = 23
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                kind_i,
  input  logic [7:0]          byte_value_i,
  input  logic [7:0]          timeout_ms_i,
  output rsfd_pkg::frame_ctrl_t ctrl_o
);

  localparam int unsigned CNT_W = $clog2(DATA_BYTES + 1);

  rsfd_pkg::parse_state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [7:0]       elapsed_q, elapsed_d;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    elapsed_d    = elapsed_q;
    ctrl_o.store = 1'b0;
    ctrl_o.data  = byte_value_i;
    ctrl_o.start = 1'b0;
    if (accept_i) begin
      if (kind_i) begin
        if (elapsed_q != 8'hFF) begin
          elapsed_d = elapsed_q + 8'd1;
        end
        if (state_q != rsfd_pkg::ST_HUNT && elapsed_d > timeout_ms_i) begin
          state_d = rsfd_pkg::ST_HUNT;
        end
      end else begin
        case (state_q)
          rsfd_pkg::ST_DATA: begin
            ctrl_o.store = 1'b1;
            count_d      = count_q + CNT_W'(1);
            if (count_q == CNT_W'(DATA_BYTES - 1)) begin
              state_d = rsfd_pkg::ST_END;
            end
          end
          rsfd_pkg::ST_END: begin
            state_d = rsfd_pkg::ST_HUNT;
            if (byte_value_i == rsfd_pkg::END_BYTE) begin
              ctrl_o.start = 1'b1;
            end
          end
          default: begin
            state_d = rsfd_pkg::ST_HUNT;
            if (byte_value_i == rsfd_pkg::HDR_BYTE) begin
              elapsed_d = 8'd0;
              count_d   = '0;
              state_d   = rsfd_pkg::ST_DATA;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rsfd_pkg::ST_HUNT;
      count_q   <= '0;
      elapsed_q <= 8'd0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule

// ----- hw/rtl/rsfd_frame_sreg.sv -----
// Frame shift register: takes data bytes in a byte at a time and
// shifts the frame out MSB first, one bit per cycle while shift_i is high. Depends on rsfd_pkg.
`timescale 1ns / 1ps

module rsfd_frame_sreg #(
  parameter int unsigned DATA_BYTES = 23
) (
  input  logic                  clk_i,
  input  rsfd_pkg::frame_ctrl_t ctrl_i,
  input  logic                  shift_i,
  output rsfd_pkg::bit_stream_t stream_o
);

  localparam int unsigned FRAME_BITS = DATA_BYTES * 8;

  logic [FRAME_BITS-1:0]        frame_q;
  logic [rsfd_pkg::FLAGS_W-1:0] flags_q;

  // Zero fill on shift: channel bits past the stored frame read as zero.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.store) begin
      frame_q <= {frame_q[FRAME_BITS-9:0], ctrl_i.data};
    end else if (shift_i) begin
      frame_q <= {frame_q[FRAME_BITS-2:0], 1'b0};
    end
    if (ctrl_i.start) begin
      flags_q <= frame_q[7:4];
    end
  end

  assign stream_o.data_bit = frame_q[FRAME_BITS-1];
  assign stream_o.flags    = flags_q;

endmodule

// ----- hw/rtl/rsfd_channel_out.sv -----
// Channel unit: gathers 11 frame bits per channel, maps the value to a
// pulse width and holds each result in the output register. Depends on rsfd_pkg.
`timescale 1ns / 1ps

module rsfd_channel_out #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  rsfd_pkg::bit_stream_t                stream_i,
  output logic                                 shift_o,
  output logic                                 busy_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [rsfd_pkg::CH_IDX_W-1:0]        channel_index_o,
  output logic [rsfd_pkg::RAW_W-1:0]           raw_value_o,
  output logic [rsfd_pkg::WIDTH_W-1:0]         pulse_width_o,
  output logic                                 digital_a_o,
  output logic                                 digital_b_o,
  output logic                                 frame_lost_o,
  output logic                                 failsafe_o,
  output logic                                 last_o
);

  localparam int unsigned RW = rsfd_pkg::RAW_W;
  localparam int unsigned BW = rsfd_pkg::BITCNT_W;
  localparam int unsigned CW = rsfd_pkg::CH_IDX_W;

  // raw * 1280 / 2047 + 880. With x = raw * 1280 = q0 * 2048 + lo,
  // x = q0 * 2047 + (q0 + lo), and q0 + lo stays below 2 * 2047.
  function automatic logic [rsfd_pkg::WIDTH_W-1:0] map_width(input logic [RW-1:0] raw);
    logic [13:0] p;
    logic [10:0] q0;
    logic [10:0] lo;
    logic [11:0] s;
    logic [10:0] q;
    p  = {1'b0, raw, 2'b00} + {3'b000, raw};
    q0 = p[13:3];
    lo = {p[2:0], 8'h00};
    s  = {1'b0, q0} + {1'b0, lo};
    q  = q0 + ((s >= 12'd2047) ? 11'd1 : 11'd0);
    return {1'b0, q} + rsfd_pkg::WIDTH_LO;
  endfunction

  logic          busy_q, busy_d;
  logic [BW-1:0] bitcnt_q, bitcnt_d;
  logic [CW-1:0] ch_q, ch_d;
  logic [RW-2:0] acc_q, acc_d;
  logic          valid_q, valid_d;
  logic          finish, out_free, load;
  logic [RW-1:0] raw_full;

  assign out_free = !valid_q || !out_stall_i;
  assign finish   = busy_q && (bitcnt_q == BW'(RW - 1));
  assign shift_o  = busy_q && (!finish || out_free);
  assign load     = shift_o && finish;
  assign raw_full = {acc_q, stream_i.data_bit};

  always_comb begin
    busy_d   = busy_q;
    bitcnt_d = bitcnt_q;
    ch_d     = ch_q;
    acc_d    = acc_q;
    valid_d  = valid_q && out_stall_i;
    if (start_i) begin
      busy_d   = 1'b1;
      bitcnt_d = '0;
      ch_d     = '0;
    end else if (shift_o) begin
      if (finish) begin
        valid_d  = 1'b1;
        bitcnt_d = '0;
        ch_d     = ch_q + CW'(1);
        if (ch_q == CW'(CHANNELS - 1)) begin
          busy_d = 1'b0;
        end
      end else begin
        acc_d    = {acc_q[RW-3:0], stream_i.data_bit};
        bitcnt_d = bitcnt_q + BW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      bitcnt_q <= '0;
      ch_q     <= '0;
      valid_q  <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      bitcnt_q <= bitcnt_d;
      ch_q     <= ch_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (load) begin
      channel_index_o <= ch_q;
      raw_value_o     <= raw_full;
      pulse_width_o   <= map_width(raw_full);
      digital_a_o     <= stream_i.flags[3];
      digital_b_o     <= stream_i.flags[2];
      frame_lost_o    <= stream_i.flags[1];
      failsafe_o      <= stream_i.flags[0];
      last_o          <= (ch_q == CW'(CHANNELS - 1));
    end
  end

  assign busy_o      = busy_q;
  assign out_valid_o = valid_q;

endmodule

// ----- hw/rtl/rc_servo_frame_decoder.sv -----
// RC servo frame decoder, top level: parser, frame shift register and
// channel unit. Depends on rsfd_pkg, rsfd_parser, rsfd_frame_sreg, rsfd_channel_out.
//
// Input channel (in_valid_i / in_stall_o): each request is either a received
// serial byte (kind_i = 0, byte_value_i) or a one millisecond tick (kind_i = 1).
// The parser hunts for header 0x0F, stores the data bytes and checks the 0x00
// end byte. Once a frame is accepted, the frame shift register moves out one
// bit per cycle while no finished channel is held by an output stall, and the
// channel unit builds each 11-bit value from 11 of those bits, CHANNELS results
// per frame. During that time in_stall_o is high; it drops as soon as the last
// channel enters the output register, so the next request is taken while the
// last result still waits.
// Output channel (out_valid_o / out_stall_i): one result per request; a
// stalled result holds, and the bit shifting pauses when a finished channel
// cannot enter the output register.
// Configuration: cfg_valid_i / cfg_ready_o writes the frame timeout in ms;
// cfg_ready_o is always high. Write it only while the block is idle.
// Reset: timeout returns to 10 ms, the parser to the header hunt, elapsed time
// to zero, and no result is pending. The frame storage is not cleared.
`timescale 1ns / 1ps

module rc_servo_frame_decoder #(
  parameter int unsigned DATA_BYTES = 23,
  parameter int unsigned CHANNELS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [7:0]                    byte_value_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [7:0]                    cfg_frame_timeout_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rsfd_pkg::CH_IDX_W-1:0] channel_index_o,
  output logic [rsfd_pkg::RAW_W-1:0]    raw_value_o,
  output logic [rsfd_pkg::WIDTH_W-1:0]  pulse_width_o,
  output logic                          digital_a_o,
  output logic                          digital_b_o,
  output logic                          frame_lost_o,
  output logic                          failsafe_o,
  output logic                          last_o
);

  logic                  accept;
  logic                  busy;
  logic                  shift;
  logic [7:0]            timeout_q;
  rsfd_pkg::frame_ctrl_t ctrl;
  rsfd_pkg::bit_stream_t stream;

  // Hold off all requests while a frame is being unpacked.
  assign in_stall_o  = busy;
  assign accept      = in_valid_i && !busy;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= rsfd_pkg::TIMEOUT_RESET;
    end else if (cfg_valid_i) begin
      timeout_q <= cfg_frame_timeout_ms_i;
    end
  end

  rsfd_parser #(
    .DATA_BYTES(DATA_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .kind_i      (kind_i),
    .byte_value_i(byte_value_i),
    .timeout_ms_i(timeout_q),
    .ctrl_o      (ctrl)
  );

  rsfd_frame_sreg #(
    .DATA_BYTES(DATA_BYTES)
  ) u_frame (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .shift_i (shift),
    .stream_o(stream)
  );

  rsfd_channel_out #(
    .CHANNELS(CHANNELS)
  ) u_chan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (ctrl.start),
    .stream_i       (stream),
    .shift_o        (shift),
    .busy_o         (busy),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .channel_index_o(channel_index_o),
    .raw_value_o    (raw_value_o),
    .pulse_width_o  (pulse_width_o),
    .digital_a_o    (digital_a_o),
    .digital_b_o    (digital_b_o),
    .frame_lost_o   (frame_lost_o),
    .failsafe_o     (failsafe_o),
    .last_o         (last_o)
  );

endmodule

// ----- hw/rtl/rsfd_checker.sv -----
// Port-level checks for the RC servo frame decoder, bound to the top level.
// Depends on rc_servo_frame_decoder.
`timescale 1ns / 1ps

module rsfd_checker #(
  parameter int unsigned CHANNELS = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        kind_i,
  input logic [7:0]  byte_value_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  channel_index_o,
  input logic [10:0] raw_value_o,
  input logic [11:0] pulse_width_o,
  input logic        last_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(raw_value_o)
      && $stable(channel_index_o))
    else $error("stalled result changed");

  // Unpacking starts only after an accepted end byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !kind_i && byte_value_i == 8'h00))
    else $error("busy without end byte");

  // The last flag marks the final channel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> channel_index_o == 4'(CHANNELS - 1))
    else $error("last on wrong channel");

  // Pulse width stays within its mapped range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pulse_width_o >= 12'd880 && pulse_width_o <= 12'd2160)
    else $error("pulse width out of range");

endmodule

bind rc_servo_frame_decoder rsfd_checker #(
  .CHANNELS(CHANNELS)
) u_rsfd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .kind_i         (kind_i),
  .byte_value_i   (byte_value_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .channel_index_o(channel_index_o),
  .raw_value_o    (raw_value_o),
  .pulse_width_o  (pulse_width_o),
  .last_o         (last_o)
);

// ----- tb/rc_servo_frame_decoder_test.sv -----
// Self-checking testbench for rc_servo_frame_decoder: drives byte and tick
// requests, predicts every channel result and compares. Depends on rsfd_pkg and rc_servo_frame_decoder.
`timescale 1ns / 1ps

module rc_servo_frame_decoder_test;

  localparam int unsigned DATA_BYTES    = 23;
  localparam int unsigned CHANNELS      = 16;
  localparam int unsigned CH_W          = rsfd_pkg::CH_IDX_W;
  localparam int unsigned RW            = rsfd_pkg::RAW_W;
  localparam int unsigned WW            = rsfd_pkg::WIDTH_W;
  localparam int unsigned BI_W          = $clog2(DATA_BYTES);
  localparam int unsigned RAW_MAX       = 2047;
  localparam int unsigned WIDTH_HI      = 2160;
  localparam logic        KIND_BYTE     = 1'b0;
  localparam logic        KIND_TICK     = 1'b1;
  localparam int unsigned SETTLE_CYCLES = 8;     // idle margin before a register write
  localparam int unsigned TAIL_CYCLES   = 250;   // longer than one full frame of results
  localparam int unsigned STALL_LIMIT   = 2000;  // cycles without any handshake
  localparam int unsigned PHASE_ITEMS   = 16;

  // One channel result as the block presents it.
  // flags: digital_a, digital_b, frame_lost, failsafe (MSB first).
  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic [RW-1:0]   raw;
    logic [WW-1:0]   width;
    logic [3:0]      flags;
    logic            last;
  } channel_t;

  // One line of the directed table. With typed set, the results listed here
  // replace the predicted ones for that request.
  typedef struct {
    bit                 new_timeout;  // drain and write the timeout first
    logic [7:0]         timeout;
    logic               kind;
    logic [7:0]         value;
    int                 reps;
    bit                 typed;
    int                 n_chan;
    logic [RW-1:0]      raw;
    logic [WW-1:0]      width;
    logic [3:0]         flags;
  } stim_row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic            kind_i = KIND_BYTE;
  logic [7:0]      byte_value_i = 8'h00;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [7:0]      cfg_frame_timeout_ms_i = 8'h00;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [CH_W-1:0] channel_index_o;
  logic [RW-1:0]   raw_value_o;
  logic [WW-1:0]   pulse_width_o;
  logic            digital_a_o;
  logic            digital_b_o;
  logic            frame_lost_o;
  logic            failsafe_o;
  logic            last_o;

  rc_servo_frame_decoder #(
    .DATA_BYTES(DATA_BYTES),
    .CHANNELS  (CHANNELS)
  ) i_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .kind_i                (kind_i),
    .byte_value_i          (byte_value_i),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_frame_timeout_ms_i(cfg_frame_timeout_ms_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .channel_index_o       (channel_index_o),
    .raw_value_o           (raw_value_o),
    .pulse_width_o         (pulse_width_o),
    .digital_a_o           (digital_a_o),
    .digital_b_o           (digital_b_o),
    .frame_lost_o          (frame_lost_o),
    .failsafe_o            (failsafe_o),
    .last_o                (last_o)
  );

  always #1 clk_i = ~clk_i;

  // Decoder shadow: parse state, collected bytes, elapsed time, timeout.
  rsfd_pkg::parse_state_e hunt_state = rsfd_pkg::ST_HUNT;
  int unsigned  byte_count = 0;
  logic [7:0]   elapsed_ms = 8'd0;
  logic [7:0]   timeout_ms = rsfd_pkg::TIMEOUT_RESET;
  logic [7:0]   frame_bytes [DATA_BYTES];

  channel_t staged_channels [$];   // results of the request just taken
  channel_t pending_channels [$];  // results still to come from the block

  bit idle_on = 1'b1;
  int errors = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int timeouts_written = 0;
  int unsigned quiet_cycles = 0;

  // Advance the shadow decoder by one request; stage any channel results.
  function automatic void decode_request(input logic k, input logic [7:0] b);
    channel_t    entry;
    int unsigned raw;
    int unsigned g;
    logic        bit_v;
    if (k == KIND_TICK) begin
      if (elapsed_ms != 8'd255) elapsed_ms++;
      if (hunt_state != rsfd_pkg::ST_HUNT && elapsed_ms > timeout_ms) begin
        hunt_state = rsfd_pkg::ST_HUNT;
      end
      return;
    end
    case (hunt_state)
      rsfd_pkg::ST_DATA: begin
        frame_bytes[BI_W'(byte_count)] = b;
        byte_count++;
        if (byte_count == DATA_BYTES) hunt_state = rsfd_pkg::ST_END;
      end
      rsfd_pkg::ST_END: begin
        hunt_state = rsfd_pkg::ST_HUNT;
        if (b == rsfd_pkg::END_BYTE) begin
          for (int ch = 0; ch < CHANNELS; ch++) begin
            raw = 0;
            // Unpack MSB first; bits past the stored bytes read as zero.
            for (int k2 = 0; k2 < RW; k2++) begin
              g = ch * RW + k2;
              bit_v = 1'b0;
              if (g / 8 < DATA_BYTES) bit_v = frame_bytes[BI_W'(g / 8)][3'(7 - g % 8)];
              raw = (raw << 1) | 32'(bit_v);
            end
            entry.ch    = CH_W'(ch);
            entry.raw   = RW'(raw);
            entry.width = WW'(raw * (WIDTH_HI - rsfd_pkg::WIDTH_LO) / RAW_MAX
                              + rsfd_pkg::WIDTH_LO);
            entry.flags = frame_bytes[DATA_BYTES - 1][7:4];
            entry.last  = (ch == CHANNELS - 1);
            staged_channels.push_back(entry);
          end
        end
      end
      default: begin
        if (b == rsfd_pkg::HDR_BYTE) begin
          elapsed_ms = 8'd0;
          byte_count = 0;
          hunt_state = rsfd_pkg::ST_DATA;
        end
      end
    endcase
  endfunction

  function automatic stim_row_t request_row(input logic k, input logic [7:0] b);
    stim_row_t r;
    r = '{1'b0, 8'h00, k, b, 1, 1'b0, 0, '0, '0, 4'h0};
    return r;
  endfunction

  function automatic logic [7:0] frame_byte(input int fill);
    case (fill)
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return ($urandom_range(0, 5) == 0) ? rsfd_pkg::HDR_BYTE : 8'($urandom);
    endcase
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Present one request at a falling edge, hold it until taken, then predict.
  // Returns at a falling edge; the caller must drive the next request or drop
  // valid in that same step.
  task automatic send_request(input stim_row_t r);
    channel_t c;
    in_valid_i   <= 1'b1;
    kind_i       <= r.kind;
    byte_value_i <= r.value;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    requests_sent++;
    staged_channels.delete();
    decode_request(r.kind, r.value);
    if (r.typed) begin
      for (int ch = 0; ch < r.n_chan; ch++) begin
        c.ch    = CH_W'(ch);
        c.raw   = r.raw;
        c.width = r.width;
        c.flags = r.flags;
        c.last  = (ch == CHANNELS - 1);
        pending_channels.push_back(c);
      end
    end else begin
      foreach (staged_channels[i]) pending_channels.push_back(staged_channels[i]);
    end
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
  endtask

  // Drop valid and hold off until every predicted result has been taken.
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (pending_channels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_timeout(input logic [7:0] v);
    cfg_valid_i            <= 1'b1;
    cfg_frame_timeout_ms_i <= v;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    timeout_ms = v;
    timeouts_written++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One random sequence: mostly complete frames, some broken ones, some noise.
  task automatic run_sequence();
    int shape;
    int fill;
    int n_data;
    shape = $urandom_range(0, 9);
    fill  = $urandom_range(0, 5);
    if (shape < 8) begin
      // shapes 0..5 complete, 6 bad end byte, 7 truncated
      n_data = (shape < 7) ? DATA_BYTES : $urandom_range(0, DATA_BYTES - 1);
      send_request(request_row(KIND_BYTE, rsfd_pkg::HDR_BYTE));
      for (int i = 0; i < n_data; i++) begin
        if ($urandom_range(0, 11) == 0) send_request(request_row(KIND_TICK, 8'($urandom)));
        send_request(request_row(KIND_BYTE, frame_byte(fill)));
      end
      if (shape < 6) begin
        send_request(request_row(KIND_BYTE, rsfd_pkg::END_BYTE));
        if ($urandom_range(0, 3) == 0) wait_drain();
      end else if (shape == 6) begin
        send_request(request_row(KIND_BYTE, 8'($urandom_range(1, 255))));
      end
    end else begin
      repeat ($urandom_range(1, 6)) send_request(request_row(1'($urandom), 8'($urandom)));
    end
  endtask

  // Output side: stall in random bursts while idling is on.
  initial begin
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare every taken result against the oldest prediction.
  always @(posedge clk_i) begin
    channel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_channels.size() == 0) begin
        $error("unexpected result on channel %0d", channel_index_o);
        errors++;
      end else begin
        want = pending_channels.pop_front();
        results_checked++;
        check_field("channel_index", want.ch, channel_index_o);
        check_field("raw_value", want.raw, raw_value_o);
        check_field("pulse_width", want.width, pulse_width_o);
        check_field("digital_a", want.flags[3], digital_a_o);
        check_field("digital_b", want.flags[2], digital_b_o);
        check_field("frame_lost", want.flags[1], frame_lost_o);
        check_field("failsafe", want.flags[0], failsafe_o);
        check_field("last", want.last, last_o);
      end
    end
  end

  // Watchdog: end the run when no handshake of any kind happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_channels.size());
      $display("rc_servo_frame_decoder_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Directed table: reset behavior, the all-ones extreme, the frame timeout.
  stim_row_t directed_rows [9] = '{
    '{1'b0, 8'h00, KIND_TICK, 8'h00,              1,          1'b1, 0,  '0, '0, 4'h0},
    '{1'b0, 8'h00, KIND_BYTE, 8'h55,              1,          1'b1, 0,  '0, '0, 4'h0},
    '{1'b0, 8'h00, KIND_BYTE, rsfd_pkg::END_BYTE, 1,          1'b1, 0,  '0, '0, 4'h0},
    '{1'b0, 8'h00, KIND_BYTE, rsfd_pkg::HDR_BYTE, 1,          1'b0, 0,  '0, '0, 4'h0},
    '{1'b0, 8'h00, KIND_BYTE, 8'hFF,              DATA_BYTES, 1'b0, 0,  '0, '0, 4'h0},
    '{1'b0, 8'h00, KIND_BYTE, rsfd_pkg::END_BYTE, 1,          1'b1, 16, 11'd2047, 12'd2160,
      4'hF},
    '{1'b1, 8'd0,  KIND_BYTE, rsfd_pkg::HDR_BYTE, 1,          1'b0, 0,  '0, '0, 4'h0},
    '{1'b0, 8'h00, KIND_TICK, 8'hA5,              1,          1'b1, 0,  '0, '0, 4'h0},
    '{1'b0, 8'h00, KIND_BYTE, rsfd_pkg::END_BYTE, 1,          1'b1, 0,  '0, '0, 4'h0}
  };

  initial begin
    logic [7:0] phase_timeouts [5];
    int         phase_start;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].new_timeout) begin
        wait_drain();
        write_timeout(directed_rows[i].timeout);
      end
      repeat (directed_rows[i].reps) send_request(directed_rows[i]);
    end

    // Random phases; the last one runs without any idling on either side.
    phase_timeouts = '{8'd255, 8'd2, 8'($urandom_range(3, 20)), 8'd0,
                       rsfd_pkg::TIMEOUT_RESET};
    for (int p = 0; p < 5; p++) begin
      wait_drain();
      write_timeout(phase_timeouts[3'(p)]);
      idle_on     = (p != 4);
      phase_start = requests_sent;
      while (requests_sent - phase_start < PHASE_ITEMS) run_sequence();
    end

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("summary: %0d requests, %0d channel results checked", requests_sent,
             results_checked);
    $display("summary: %0d timeout writes, 0 ms and 255 ms among them", timeouts_written);
    if (errors == 0 && pending_channels.size() == 0) begin
      $display("rc_servo_frame_decoder_test: clean");
    end else begin
      $display("rc_servo_frame_decoder_test: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/rsfd_pkg.sv
hw/rtl/rsfd_parser.sv
hw/rtl/rsfd_frame_sreg.sv
hw/rtl/rsfd_channel_out.sv
hw/rtl/rc_servo_frame_decoder.sv
hw/rtl/rsfd_checker.sv
tb/rc_servo_frame_decoder_test.sv
